// ===== src/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg - shared types and constants for the playfair digraph encryptor
// letter codes, key square geometry, operation codes, state codes and the
// structs passed between the store, the lanes and the merge stage
// ----------------------------------------------------------------------------
package pfe_pkg;

	// letter coding: 0 = a through 25 = z
	localparam int LETTER_W = 5;
	localparam int ALPHABET = 26;
	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_LAST = 5'(ALPHABET - 1);

	// key square geometry
	localparam int GRID_SIDE = 5;
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int POS_W = $clog2(CELLS);
	localparam int COORD_W = $clog2(GRID_SIDE);

	// operation codes
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_KEY   = 2'd1,
		OP_PAIR  = 2'd2
	} op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOK,
		ST_CALC,
		ST_OUT
	} state_t;

	// one write into the key square and the position table
	typedef struct packed {
		logic                en;
		logic [LETTER_W-1:0] letter;
		logic [POS_W-1:0]    pos;
	} store_wr_t;

	// what one lane finds about its letter's position
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [POS_W-1:0]   base;
		logic [POS_W-1:0]   right;
		logic [POS_W-1:0]   down;
	} lane_info_t;

endpackage

// ===== src/pfe_store.sv =====
// ----------------------------------------------------------------------------
// pfe_store - key square and letter position memories
// one write port shared by both tables, two registered read ports on each
// ----------------------------------------------------------------------------
module pfe_store (
	input  logic                             clk,
	input  pfe_pkg::store_wr_t               wr,
	input  logic [pfe_pkg::LETTER_W-1:0]     place_rd_a,
	input  logic [pfe_pkg::LETTER_W-1:0]     place_rd_b,
	input  logic [pfe_pkg::POS_W-1:0]        sq_rd_a,
	input  logic [pfe_pkg::POS_W-1:0]        sq_rd_b,
	output logic [pfe_pkg::POS_W-1:0]        place_a_q,
	output logic [pfe_pkg::POS_W-1:0]        place_b_q,
	output logic [pfe_pkg::LETTER_W-1:0]     sq_a_q,
	output logic [pfe_pkg::LETTER_W-1:0]     sq_b_q
);

	logic [pfe_pkg::LETTER_W-1:0] square_mem [pfe_pkg::CELLS];
	logic [pfe_pkg::POS_W-1:0]    place_mem  [pfe_pkg::ALPHABET];

	// letter goes to the next free cell, its position is recorded
	always_ff @(posedge clk) begin
		if (wr.en) begin
			square_mem[wr.pos] <= wr.letter;
			place_mem[wr.letter] <= wr.pos;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		place_a_q <= place_mem[place_rd_a];
		place_b_q <= place_mem[place_rd_b];
		sq_a_q <= square_mem[sq_rd_a];
		sq_b_q <= square_mem[sq_rd_b];
	end

endmodule

// ===== src/pfe_lane.sv =====
// ----------------------------------------------------------------------------
// pfe_lane - position decode for one letter of the pair
// splits a square position into row and column and forms the wrapped
// neighbor positions to the right and below
// ----------------------------------------------------------------------------
module pfe_lane (
	input  logic [pfe_pkg::POS_W-1:0] pos,
	output pfe_pkg::lane_info_t       info
);

	// row search over the row start positions
	always_comb begin
		logic [pfe_pkg::POS_W-1:0]   base;
		logic [pfe_pkg::COORD_W-1:0] row;
		logic [pfe_pkg::COORD_W-1:0] col;
		base = '0;
		row = '0;
		for (int r = 0; r < pfe_pkg::GRID_SIDE; r++) begin
			if (pos >= pfe_pkg::POS_W'(r * pfe_pkg::GRID_SIDE)) begin
				base = pfe_pkg::POS_W'(r * pfe_pkg::GRID_SIDE);
				row = pfe_pkg::COORD_W'(r);
			end
		end
		col = pfe_pkg::COORD_W'(pos - base);

		info.row = row;
		info.col = col;
		info.base = base;
		// wrap to the start of the row
		if (col == pfe_pkg::COORD_W'(pfe_pkg::GRID_SIDE - 1))
			info.right = base;
		else
			info.right = pos + pfe_pkg::POS_W'(1);
		// wrap to the top of the column
		if (row == pfe_pkg::COORD_W'(pfe_pkg::GRID_SIDE - 1))
			info.down = pfe_pkg::POS_W'(col);
		else
			info.down = pos + pfe_pkg::POS_W'(pfe_pkg::GRID_SIDE);
	end

endmodule

// ===== src/pfe_merge.sv =====
// ----------------------------------------------------------------------------
// pfe_merge - combines the two lanes into the ciphertext cell positions
// same row shifts right, same column shifts down, else rectangle corners
// ----------------------------------------------------------------------------
module pfe_merge (
	input  pfe_pkg::lane_info_t       lane_a,
	input  pfe_pkg::lane_info_t       lane_b,
	output logic [pfe_pkg::POS_W-1:0] pos_x,
	output logic [pfe_pkg::POS_W-1:0] pos_y
);

	// rule selection
	always_comb begin
		if (lane_a.row == lane_b.row) begin
			pos_x = lane_a.right;
			pos_y = lane_b.right;
		end else if (lane_a.col == lane_b.col) begin
			pos_x = lane_a.down;
			pos_y = lane_b.down;
		end else begin
			pos_x = lane_a.base + pfe_pkg::POS_W'(lane_b.col);
			pos_y = lane_b.base + pfe_pkg::POS_W'(lane_a.col);
		end
	end

endmodule

// ===== src/playfair_digraph_encrypt_unit.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_unit - playfair encryption with a 5x5 key square
// clear and key transactions are taken while idle; a pair on a complete square
// passes position read, square read and output load before its result shows,
// and the next transaction waits for the output load. the first pair after a
// clear adds an alphabet walk that completes the square, one letter a cycle.
// reset clears the control state; square contents are undefined until built.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   operation,
	input  logic [pfe_pkg::LETTER_W-1:0] letter_one,
	input  logic [pfe_pkg::LETTER_W-1:0] letter_two,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pfe_pkg::LETTER_W-1:0] cipher_one,
	output logic [pfe_pkg::LETTER_W-1:0] cipher_two
);

	pfe_pkg::state_t state_q, state_nxt;

	logic [pfe_pkg::ALPHABET-1:0] used_q;
	logic [pfe_pkg::POS_W-1:0]    fill_q;
	logic                         complete_q;
	logic [pfe_pkg::LETTER_W-1:0] walk_q;
	logic [pfe_pkg::LETTER_W-1:0] a_q, b_q;
	logic                         pair_ok_q;
	logic                         out_valid_q;
	logic [pfe_pkg::LETTER_W-1:0] cipher_one_q, cipher_two_q;

	logic                         accept;
	logic                         out_load;
	logic                         a_ok, b_ok;
	logic [pfe_pkg::LETTER_W-1:0] a_in, b_in;
	logic [pfe_pkg::LETTER_W-1:0] cand_letter;
	logic                         cand_ok;
	logic                         key_write;
	pfe_pkg::store_wr_t           wr;
	logic [pfe_pkg::LETTER_W-1:0] place_rd_a, place_rd_b;
	logic [pfe_pkg::POS_W-1:0]    place_a, place_b;
	logic [pfe_pkg::POS_W-1:0]    pos_x, pos_y;
	logic [pfe_pkg::LETTER_W-1:0] sq_a, sq_b;
	pfe_pkg::lane_info_t          lane_a, lane_b;

	// input transaction and pair letter repair (j becomes i)
	assign accept = in_valid && !in_stall;
	assign a_ok = letter_one <= pfe_pkg::LETTER_LAST;
	assign b_ok = letter_two <= pfe_pkg::LETTER_LAST;
	assign a_in = (letter_one == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : letter_one;
	assign b_in = (letter_two == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : letter_two;

	// position read straight from the ports when idle, from the held pair after
	assign place_rd_a = (state_q == pfe_pkg::ST_IDLE) ? (a_ok ? a_in : '0) : a_q;
	assign place_rd_b = (state_q == pfe_pkg::ST_IDLE) ? (b_ok ? b_in : '0) : b_q;

	// candidate letter for the square: key letter or alphabet walk
	assign cand_letter = (state_q == pfe_pkg::ST_FILL) ? walk_q : letter_one;
	assign cand_ok = (cand_letter <= pfe_pkg::LETTER_LAST)
		&& (cand_letter != pfe_pkg::LETTER_J)
		&& !used_q[cand_letter]
		&& (fill_q < pfe_pkg::POS_W'(pfe_pkg::CELLS));
	assign key_write = accept && (operation == pfe_pkg::OP_KEY) && !complete_q;
	assign wr.en = cand_ok && ((state_q == pfe_pkg::ST_FILL) || key_write);
	assign wr.letter = cand_letter;
	assign wr.pos = fill_q;

	pfe_store u_store (
		.clk        (clk),
		.wr         (wr),
		.place_rd_a (place_rd_a),
		.place_rd_b (place_rd_b),
		.sq_rd_a    (pos_x),
		.sq_rd_b    (pos_y),
		.place_a_q  (place_a),
		.place_b_q  (place_b),
		.sq_a_q     (sq_a),
		.sq_b_q     (sq_b)
	);

	// one lane per letter of the pair
	pfe_lane u_lane_a (
		.pos  (place_a),
		.info (lane_a)
	);

	pfe_lane u_lane_b (
		.pos  (place_b),
		.info (lane_b)
	);

	pfe_merge u_merge (
		.lane_a (lane_a),
		.lane_b (lane_b),
		.pos_x  (pos_x),
		.pos_y  (pos_y)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_nxt = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			pfe_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept && (operation == pfe_pkg::OP_PAIR)) begin
					if (!complete_q)
						state_nxt = pfe_pkg::ST_FILL;
					else if (a_ok && b_ok)
						state_nxt = pfe_pkg::ST_CALC;
				end
			end
			pfe_pkg::ST_FILL: begin
				if (walk_q == pfe_pkg::LETTER_LAST)
					state_nxt = pair_ok_q ? pfe_pkg::ST_LOOK : pfe_pkg::ST_IDLE;
			end
			pfe_pkg::ST_LOOK: begin
				state_nxt = pfe_pkg::ST_CALC;
			end
			pfe_pkg::ST_CALC: begin
				state_nxt = pfe_pkg::ST_OUT;
			end
			pfe_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_nxt = pfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pfe_pkg::ST_IDLE;
			end
		endcase
	end

	// square bookkeeping: used letters, fill count, completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
			complete_q <= 1'b0;
			walk_q <= '0;
		end else begin
			if (accept && (operation == pfe_pkg::OP_CLEAR)) begin
				used_q <= '0;
				fill_q <= '0;
				complete_q <= 1'b0;
			end else if (wr.en) begin
				used_q[wr.letter] <= 1'b1;
				fill_q <= fill_q + pfe_pkg::POS_W'(1);
			end
			if (state_q == pfe_pkg::ST_FILL) begin
				walk_q <= walk_q + pfe_pkg::LETTER_W'(1);
				if (walk_q == pfe_pkg::LETTER_LAST)
					complete_q <= 1'b1;
			end else begin
				walk_q <= '0;
			end
		end
	end

	// held pair letters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ok_q <= 1'b0;
		end else if (accept && (operation == pfe_pkg::OP_PAIR)) begin
			pair_ok_q <= a_ok && b_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == pfe_pkg::OP_PAIR)) begin
			a_q <= a_in;
			b_q <= b_in;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cipher_one_q <= sq_a;
			cipher_two_q <= sq_b;
		end
	end

	assign out_valid = out_valid_q;
	assign cipher_one = cipher_one_q;
	assign cipher_two = cipher_two_q;

	// a result only appears from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pfe_pkg::ST_OUT))
		else $error("result without a finished pair lookup");

	// a complete square holds exactly one letter per cell
	assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (fill_q == pfe_pkg::POS_W'(pfe_pkg::CELLS)))
		else $error("square marked complete with wrong fill count");

	// the fill count never runs past the square
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pfe_pkg::POS_W'(pfe_pkg::CELLS))
		else $error("fill count past the square");

	// j never leaves the block as ciphertext
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cipher_one_q != pfe_pkg::LETTER_J) && (cipher_two_q != pfe_pkg::LETTER_J))
		else $error("ciphertext holds the letter j");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for playfair_digraph_encrypt_unit
// a directed table covers the default square, wrap-around on rows and columns,
// the rectangle rule, j folding into i, out-of-range letters, ignored keys and
// the unused operation. random clear / key phrase / pair runs follow. every
// accepted transaction goes through a local playfair model, and each result
// pair is compared in order against the queue of expected cipher pairs, with
// random idle bursts on both the input and output handshakes
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1025;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 60;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [pfe_pkg::LETTER_W-1:0] one;
		logic [pfe_pkg::LETTER_W-1:0] two;
	} cipher_pair_t;

	// one row of the directed table; pinned rows carry a hand-read expectation
	typedef struct packed {
		logic [1:0]                   op;
		logic [pfe_pkg::LETTER_W-1:0] in_a;
		logic [pfe_pkg::LETTER_W-1:0] in_b;
		bit                           pinned;
		bit                           gives;
		logic [pfe_pkg::LETTER_W-1:0] want_one;
		logic [pfe_pkg::LETTER_W-1:0] want_two;
	} vector_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   operation = pfe_pkg::OP_CLEAR;
	logic [pfe_pkg::LETTER_W-1:0] letter_one = '0;
	logic [pfe_pkg::LETTER_W-1:0] letter_two = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [pfe_pkg::LETTER_W-1:0] cipher_one;
	logic [pfe_pkg::LETTER_W-1:0] cipher_two;

	bit                           idling_on = 1'b1;
	int unsigned                  mismatches = 0;
	int unsigned                  cycles = 0;
	cipher_pair_t                 cipher_pairs_due [$];

	// model state: key square, letter positions, fill progress
	logic [pfe_pkg::LETTER_W-1:0] key_square [pfe_pkg::CELLS];
	logic [pfe_pkg::POS_W-1:0]    square_pos [pfe_pkg::ALPHABET];
	logic [pfe_pkg::ALPHABET-1:0] letters_taken = '0;
	int unsigned                  cells_filled = 0;
	bit                           square_built = 1'b0;

	playfair_digraph_encrypt_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.letter_one (letter_one),
		.letter_two (letter_two),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cipher_one (cipher_one),
		.cipher_two (cipher_two)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// append a letter to the square unless it is j, a repeat, out of range or full
	function automatic void add_to_square(logic [pfe_pkg::LETTER_W-1:0] l);
		if (l < pfe_pkg::ALPHABET && l != pfe_pkg::LETTER_J
				&& cells_filled < pfe_pkg::CELLS) begin
			if (!letters_taken[l]) begin
				key_square[cells_filled] = l;
				square_pos[l] = pfe_pkg::POS_W'(cells_filled);
				letters_taken[l] = 1'b1;
				cells_filled++;
			end
		end
	endfunction

	function automatic logic [pfe_pkg::LETTER_W-1:0] cell_of(int r, int c);
		return key_square[(r % pfe_pkg::GRID_SIDE) * pfe_pkg::GRID_SIDE
			+ (c % pfe_pkg::GRID_SIDE)];
	endfunction

	// advance the model by one transaction; returns 1 when a cipher pair comes out
	function automatic bit encipher(logic [1:0] op, logic [pfe_pkg::LETTER_W-1:0] a,
			logic [pfe_pkg::LETTER_W-1:0] b, output logic [pfe_pkg::LETTER_W-1:0] x,
			output logic [pfe_pkg::LETTER_W-1:0] y);
		bit produced;
		int pa, pb, ra, ca, rb, cb;
		logic [pfe_pkg::LETTER_W-1:0] fa, fb;
		produced = 1'b0;
		x = '0;
		y = '0;
		case (op)
			pfe_pkg::OP_CLEAR: begin
				letters_taken = '0;
				cells_filled = 0;
				square_built = 1'b0;
			end
			pfe_pkg::OP_KEY: begin
				if (!square_built)
					add_to_square(a);
			end
			pfe_pkg::OP_PAIR: begin
				if (!square_built) begin
					for (int l = 0; l < pfe_pkg::ALPHABET; l++)
						add_to_square(pfe_pkg::LETTER_W'(l));
					square_built = 1'b1;
				end
				if (a < pfe_pkg::ALPHABET && b < pfe_pkg::ALPHABET) begin
					fa = (a == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : a;
					fb = (b == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : b;
					pa = int'(square_pos[fa]) % pfe_pkg::CELLS;
					pb = int'(square_pos[fb]) % pfe_pkg::CELLS;
					ra = pa / pfe_pkg::GRID_SIDE;
					ca = pa % pfe_pkg::GRID_SIDE;
					rb = pb / pfe_pkg::GRID_SIDE;
					cb = pb % pfe_pkg::GRID_SIDE;
					if (ra == rb) begin
						x = cell_of(ra, ca + 1);
						y = cell_of(rb, cb + 1);
					end else if (ca == cb) begin
						x = cell_of(ra + 1, ca);
						y = cell_of(rb + 1, cb);
					end else begin
						x = cell_of(ra, cb);
						y = cell_of(rb, ca);
					end
					produced = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return produced;
	endfunction

	// drive one transaction, hold it until accepted, then log the expectation
	task automatic push_transaction(logic [1:0] op, logic [pfe_pkg::LETTER_W-1:0] a,
			logic [pfe_pkg::LETTER_W-1:0] b, bit pinned = 1'b0, bit gives = 1'b0,
			logic [pfe_pkg::LETTER_W-1:0] want_one = '0,
			logic [pfe_pkg::LETTER_W-1:0] want_two = '0);
		int gap;
		bit produced;
		logic [pfe_pkg::LETTER_W-1:0] x, y;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		letter_one <= a;
		letter_two <= b;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		produced = encipher(op, a, b, x, y);
		if (pinned) begin
			produced = gives;
			x = want_one;
			y = want_two;
		end
		if (produced)
			cipher_pairs_due.push_back('{x, y});
	endtask

	function automatic logic [pfe_pkg::LETTER_W-1:0] pick_letter();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return pfe_pkg::LETTER_W'($urandom_range(pfe_pkg::ALPHABET, 31));
		if (roll == 1)
			return pfe_pkg::LETTER_J;
		return pfe_pkg::LETTER_W'($urandom_range(0, pfe_pkg::ALPHABET - 1));
	endfunction

	// output stall bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		cipher_pair_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (cipher_pairs_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %0d %0d", cipher_one, cipher_two));
			end else begin
				due = cipher_pairs_due.pop_front();
				if (cipher_one !== due.one)
					flag_mismatch($sformatf("cipher_one got %0d want %0d", cipher_one, due.one));
				if (cipher_two !== due.two)
					flag_mismatch($sformatf("cipher_two got %0d want %0d", cipher_two, due.two));
			end
		end
	end

	// directed table; default square rows are a b c d e / f g h i k / l m n o p / ...
	vector_row_t vectors [25];

	initial begin
		int n_counted;
		int n_keys;
		int n_pairs;
		bit drained;
		logic [pfe_pkg::LETTER_W-1:0] a, b;

		vectors = '{
			'{pfe_pkg::OP_PAIR,  5'd0,  5'd0,  1'b1, 1'b1, 5'd1,  5'd1},  // a a, same row
			'{pfe_pkg::OP_PAIR,  5'd25, 5'd25, 1'b1, 1'b1, 5'd21, 5'd21}, // z z, row wrap
			'{pfe_pkg::OP_PAIR,  5'd0,  5'd25, 1'b1, 1'b1, 5'd4,  5'd21}, // a z, rectangle
			'{pfe_pkg::OP_PAIR,  5'd0,  5'd21, 1'b1, 1'b1, 5'd5,  5'd0},  // a v, column wrap
			'{pfe_pkg::OP_PAIR,  5'd9,  5'd9,  1'b1, 1'b1, 5'd10, 5'd10}, // j j folds to i i
			'{pfe_pkg::OP_PAIR,  5'd9,  5'd4,  1'b1, 1'b1, 5'd10, 5'd3},  // j e
			'{pfe_pkg::OP_PAIR,  5'd26, 5'd3,  1'b1, 1'b0, 5'd0,  5'd0},  // first out of range
			'{pfe_pkg::OP_PAIR,  5'd0,  5'd31, 1'b1, 1'b0, 5'd0,  5'd0},  // second out of range
			'{pfe_pkg::OP_KEY,   5'd4,  5'd0,  1'b1, 1'b0, 5'd0,  5'd0},  // key after completion
			'{pfe_pkg::OP_PAIR,  5'd4,  5'd3,  1'b1, 1'b1, 5'd0,  5'd4},  // square unchanged
			'{OP_UNUSED,         5'd5,  5'd5,  1'b1, 1'b0, 5'd0,  5'd0},
			'{pfe_pkg::OP_CLEAR, 5'd31, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0},
			'{pfe_pkg::OP_KEY,   5'd15, 5'd31, 1'b0, 1'b0, 5'd0,  5'd0},  // p
			'{pfe_pkg::OP_KEY,   5'd11, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // l
			'{pfe_pkg::OP_KEY,   5'd0,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // a
			'{pfe_pkg::OP_KEY,   5'd24, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // y
			'{pfe_pkg::OP_KEY,   5'd9,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // j skipped
			'{pfe_pkg::OP_KEY,   5'd31, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // out of range
			'{pfe_pkg::OP_KEY,   5'd0,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // repeat
			'{pfe_pkg::OP_KEY,   5'd5,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},  // f
			'{pfe_pkg::OP_PAIR,  5'd31, 5'd26, 1'b1, 1'b0, 5'd0,  5'd0},  // completes, no result
			'{pfe_pkg::OP_PAIR,  5'd7,  5'd8,  1'b0, 1'b0, 5'd0,  5'd0},
			'{pfe_pkg::OP_PAIR,  5'd23, 5'd23, 1'b0, 1'b0, 5'd0,  5'd0},  // identical letters
			'{pfe_pkg::OP_CLEAR, 5'd0,  5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
			'{pfe_pkg::OP_PAIR,  5'd19, 5'd18, 1'b0, 1'b0, 5'd0,  5'd0}   // empty key phrase
		};

		// reset
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (vectors[i])
			push_transaction(vectors[i].op, vectors[i].in_a, vectors[i].in_b,
				vectors[i].pinned, vectors[i].gives, vectors[i].want_one,
				vectors[i].want_two);

		// random runs of clear, key phrase, pairs
		n_counted = 0;
		drained = 1'b0;
		while (n_counted < RANDOM_ITEMS) begin
			idling_on = ((n_counted / 120) % 4 != 3) && (n_counted < RANDOM_ITEMS - 150);

			// sender holds off until the result queue drains
			if (!drained && n_counted >= RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (cipher_pairs_due.size() != 0);
				drained = 1'b1;
			end

			if ($urandom_range(0, 9) != 0) begin
				push_transaction(pfe_pkg::OP_CLEAR, pfe_pkg::LETTER_W'($urandom),
					pfe_pkg::LETTER_W'($urandom));
				n_counted++;
			end
			n_keys = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30)
				: $urandom_range(0, 12);
			repeat (n_keys) begin
				a = pick_letter();
				push_transaction(pfe_pkg::OP_KEY, a, pfe_pkg::LETTER_W'($urandom));
				n_counted++;
			end
			n_pairs = $urandom_range(1, 12);
			repeat (n_pairs) begin
				a = pick_letter();
				b = ($urandom_range(0, 7) == 0) ? a : pick_letter();
				push_transaction(pfe_pkg::OP_PAIR, a, b);
				n_counted++;
			end
			// noise: unused operation or a stray key on a finished square
			if ($urandom_range(0, 3) == 0) begin
				push_transaction(($urandom_range(0, 1) != 0) ? OP_UNUSED : pfe_pkg::OP_KEY,
					pfe_pkg::LETTER_W'($urandom), pfe_pkg::LETTER_W'($urandom));
				n_counted++;
			end
		end
		idling_on = 1'b0;

		// drain and let the pipeline settle
		in_valid <= 1'b0;
		while (cipher_pairs_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && cipher_pairs_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
